/* rtl/ufrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufrr_pkg
// Shared types and constants of the udp flow rule rewriter: request and
// response payloads, rule entry layout, action codes, controller commands.
// ----------------------------------------------------------------------------
package ufrr_pkg;

   localparam int RULE_DEPTH = 1024;
   localparam int RULE_IDX_W = $clog2(RULE_DEPTH);
   localparam int RULE_CNT_W = RULE_IDX_W + 1;

   localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;

   localparam logic KIND_PACKET     = 1'b0;
   localparam logic KIND_RULE_WRITE = 1'b1;

   localparam logic [2:0] ACT_FORWARD       = 3'd0;
   localparam logic [2:0] ACT_DROP_ARP      = 3'd1;
   localparam logic [2:0] ACT_DROP_NON_UDP  = 3'd2;
   localparam logic [2:0] ACT_DROP_NO_MATCH = 3'd3;
   localparam logic [2:0] ACT_RULE_WRITTEN  = 3'd4;

   localparam logic [1:0] CSR_RULE_COUNT = 2'd0;
   localparam logic [1:0] CSR_SOURCE_MAC = 2'd1;
   localparam logic [1:0] CSR_DEST_MAC   = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [31:0] source_addr;
      logic [15:0] dest_port;
      logic [31:0] dest_addr;
      logic [9:0]  rule_index;
   } ufrr_req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] out_dest_addr;
      logic [9:0]  matched_rule;
      logic [31:0] udp_received;
      logic [31:0] forwarded_count;
   } ufrr_rsp_type;

   typedef struct packed {
      logic [31:0] match_source;
      logic [15:0] match_port;
      logic [31:0] replacement_dest;
   } ufrr_rule_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan;
      logic emit;
   } ufrr_cmd_type;

   typedef struct packed {
      logic is_udp;
      logic search_done;
      logic rsp_free;
   } ufrr_status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } ufrr_state_type;

endpackage

/* rtl/ufrr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufrr_ctrl
// Request sequencer: takes one request, classifies it, runs the rule search
// for udp packets and hands the result to the output register.
// ----------------------------------------------------------------------------
module ufrr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ufrr_pkg::ufrr_status_type status,
   output ufrr_pkg::ufrr_cmd_type    cmd
);
   import ufrr_pkg::*;

   ufrr_state_type state_ff;
   ufrr_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.scan_start = status.is_udp;
            state_in       = status.is_udp ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (status.search_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.emit = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/ufrr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufrr_datapath
// Rule memory, search address counter, match compare, packet counters,
// rule count register and the response output register.
// ----------------------------------------------------------------------------
module ufrr_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ufrr_pkg::ufrr_cmd_type    cmd,
   output ufrr_pkg::ufrr_status_type status,
   input  ufrr_pkg::ufrr_req_type    req_data,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [47:0]               csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ufrr_pkg::ufrr_rsp_type    rsp_data
);
   import ufrr_pkg::*;

   localparam logic [RULE_CNT_W-1:0] DEPTH_CNT = RULE_CNT_W'(RULE_DEPTH);

   ufrr_rule_type rule_mem [RULE_DEPTH];

   ufrr_req_type            req_ff;
   logic [RULE_CNT_W-1:0]   rule_count_ff, rule_count_in;
   logic [RULE_CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [RULE_IDX_W-1:0]   rd_idx_ff;
   ufrr_rule_type           rd_entry_ff;
   logic                    found_ff, found_in;
   logic [RULE_IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [31:0]             match_dest_ff, match_dest_in;
   logic [31:0]             udp_cnt_ff, udp_cnt_in;
   logic [31:0]             fwd_cnt_ff, fwd_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ufrr_rsp_type            rsp_ff, rsp_in;

   logic [RULE_CNT_W-1:0]   limit;
   logic                    issue_ok;
   logic                    hit;
   logic                    wr_en;

   assign limit    = (rule_count_ff > DEPTH_CNT) ? DEPTH_CNT : rule_count_ff;
   assign issue_ok = (scan_idx_ff < limit);
   assign hit      = rd_valid_ff
                     && (rd_entry_ff.match_source == req_ff.source_addr)
                     && (rd_entry_ff.match_port == req_ff.dest_port);
   assign wr_en    = cmd.emit && (req_ff.kind == KIND_RULE_WRITE)
                     && (32'(req_ff.rule_index) < RULE_DEPTH);

   assign status.is_udp      = (req_ff.kind == KIND_PACKET)
                               && (req_ff.eth_type != ETH_TYPE_ARP)
                               && (req_ff.ip_protocol == PROTO_UDP);
   assign status.search_done = hit || (!rd_valid_ff && !issue_ok);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // mac rewrite registers are not kept here
   always_comb begin
      rule_count_in = rule_count_ff;
      if (csr_write_en && (csr_index == CSR_RULE_COUNT)) begin
         rule_count_in = csr_wdata[RULE_CNT_W-1:0];
      end
   end

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = cmd.scan && issue_ok && !hit;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_dest_in = match_dest_ff;
      udp_cnt_in    = udp_cnt_ff;
      fwd_cnt_in    = fwd_cnt_ff;
      if (cmd.load) begin
         found_in = 1'b0;
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         udp_cnt_in  = udp_cnt_ff + 32'd1;
      end
      if (rd_valid_in) begin
         scan_idx_in = scan_idx_ff + RULE_CNT_W'(1);
      end
      if (cmd.scan && hit) begin
         found_in      = 1'b1;
         match_idx_in  = rd_idx_ff;
         match_dest_in = rd_entry_ff.replacement_dest;
         fwd_cnt_in    = fwd_cnt_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_in.udp_received    = udp_cnt_ff;
      rsp_in.forwarded_count = fwd_cnt_ff;
      rsp_in.out_dest_addr   = req_ff.dest_addr;
      rsp_in.matched_rule    = '0;
      priority if (req_ff.kind == KIND_RULE_WRITE) begin
         rsp_in.action       = ACT_RULE_WRITTEN;
         rsp_in.matched_rule = req_ff.rule_index;
      end else if (req_ff.eth_type == ETH_TYPE_ARP) begin
         rsp_in.action = ACT_DROP_ARP;
      end else if (req_ff.ip_protocol != PROTO_UDP) begin
         rsp_in.action = ACT_DROP_NON_UDP;
      end else if (found_ff) begin
         rsp_in.action        = ACT_FORWARD;
         rsp_in.out_dest_addr = match_dest_ff;
         rsp_in.matched_rule  = 10'(match_idx_ff);
      end else begin
         rsp_in.action = ACT_DROP_NO_MATCH;
      end
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem[req_ff.rule_index[RULE_IDX_W-1:0]] <= {req_ff.source_addr,
            req_ff.dest_port, req_ff.dest_addr};
      end
      rd_entry_ff <= rule_mem[scan_idx_ff[RULE_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      rd_idx_ff     <= scan_idx_ff[RULE_IDX_W-1:0];
      match_idx_ff  <= match_idx_in;
      match_dest_ff <= match_dest_in;
      scan_idx_ff   <= scan_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         udp_cnt_ff    <= '0;
         fwd_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rule_count_ff <= rule_count_in;
         rd_valid_ff   <= rd_valid_in;
         found_ff      <= found_in;
         udp_cnt_ff    <= udp_cnt_in;
         fwd_cnt_ff    <= fwd_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/udp_flow_rule_rewriter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_flow_rule_rewriter
// First-match udp flow classifier with destination rewrite and rule table.
//
// A request is either a packet header summary or a rule table write. Arp
// packets and non-udp packets are dropped; udp packets are counted and the
// rules from entry zero up to rule_count-1 are searched for the first match
// on source address and destination port. Each request gives one response.
// Both channels are valid/stall; the block takes one request at a time and
// holds req_stall high until its response is in the output register.
// For rule writes and drops, the request passes the check and done states
// before its response is registered; udp packets also pass the search state.
// The search reads one rule entry per cycle from the single read port of the
// rule memory and stops at the first match or after n entries, where n is
// rule_count saturated at 1024 (no entry is read when it is zero). The next
// request can be accepted in the cycle after the response is loaded.
// When the receiver stalls, the response stays in the output register; the
// next request is still accepted and processed, and waits only to load its
// own response. Reset clears the counters, rule_count and the handshakes;
// rule entries are undefined until written. Csr writes go in idle gaps.
// ----------------------------------------------------------------------------
module udp_flow_rule_rewriter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ufrr_pkg::ufrr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ufrr_pkg::ufrr_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [47:0]            csr_wdata
);
   import ufrr_pkg::*;

   ufrr_cmd_type    cmd;
   ufrr_status_type status;

   ufrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ufrr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a request without going busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a request in progress");

   a_drop_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == ACT_DROP_ARP
                     || rsp_data.action == ACT_DROP_NON_UDP
                     || rsp_data.action == ACT_DROP_NO_MATCH))
      |-> (rsp_data.matched_rule == '0))
      else $error("dropped packet reports a rule index");

endmodule
